FILE: rtl/stss_pkg.sv
package stss_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int NAME_BYTES  = 256;

    localparam logic [1:0] MODE_APPEND  = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_SORTED  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_TAKE     = 5'd1;
    localparam logic [OP_W-1:0] OP_APP_RD   = 5'd2;
    localparam logic [OP_W-1:0] OP_APP_WR   = 5'd3;
    localparam logic [OP_W-1:0] OP_APP_END  = 5'd4;
    localparam logic [OP_W-1:0] OP_FULL     = 5'd5;
    localparam logic [OP_W-1:0] OP_OUT_LOAD = 5'd6;
    localparam logic [OP_W-1:0] OP_PERM_RD  = 5'd7;
    localparam logic [OP_W-1:0] OP_LAT_PA   = 5'd8;
    localparam logic [OP_W-1:0] OP_QCMP_RD  = 5'd9;
    localparam logic [OP_W-1:0] OP_K_INC    = 5'd10;
    localparam logic [OP_W-1:0] OP_LIN_HIT  = 5'd11;
    localparam logic [OP_W-1:0] OP_I_INC    = 5'd12;
    localparam logic [OP_W-1:0] OP_NFND     = 5'd13;
    localparam logic [OP_W-1:0] OP_SRT_PASS = 5'd14;
    localparam logic [OP_W-1:0] OP_SRT_RB   = 5'd15;
    localparam logic [OP_W-1:0] OP_LAT_PB   = 5'd16;
    localparam logic [OP_W-1:0] OP_RCMP_RA  = 5'd17;
    localparam logic [OP_W-1:0] OP_RCMP_RB  = 5'd18;
    localparam logic [OP_W-1:0] OP_SWAP_A   = 5'd19;
    localparam logic [OP_W-1:0] OP_SWAP_B   = 5'd20;
    localparam logic [OP_W-1:0] OP_BIN_MID  = 5'd21;
    localparam logic [OP_W-1:0] OP_BIN_PRD  = 5'd22;
    localparam logic [OP_W-1:0] OP_BIN_HIT  = 5'd23;
    localparam logic [OP_W-1:0] OP_BIN_LT   = 5'd24;
    localparam logic [OP_W-1:0] OP_BIN_GT   = 5'd25;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] slot_index;
        logic [7:0] entry_total;
        logic       truncated;
    } out_item_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic       in_term;
        logic [1:0] in_mode;
        logic       full;
        logic       cnt_lt2;
        logic       i_end;
        logic       ip1_end;
        logic       bin_end;
        logic       swapped;
        logic       k_last;
        logic       q_stop;
        logic       qc_ne;
        logic       qc_gt;
        logic       qc_z;
        logic       rc_ne;
        logic       rc_gt;
        logic       rc_z;
        logic       out_free;
    } dp_status_t;

endpackage

FILE: rtl/string_table_sort_and_search.sv
// Nonzero byte: one transfer per cycle while idle, collected with no result. Append: a read
// and a write per byte, terminator included; input is ready again once the result is loaded.
// Linear search: per slot a permutation read and latch, a read and compare per byte, on the
// single-port name memory. Sorted search: up to N bubble passes of N-1 pairs, per pair a
// permutation read and latch, two reads and a compare per byte; then up to log2(N)+1 probes,
// each a midpoint, then slot steps. Reset clears count and control at once, not the memories.
module string_table_sort_and_search #(
    parameter int MAX_ENTRIES = stss_pkg::MAX_ENTRIES,
    parameter int NAME_BYTES  = stss_pkg::NAME_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  stss_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stss_pkg::out_item_t  out_data
);

    stss_pkg::cmd_t       cmd;
    stss_pkg::dp_status_t sts;

    stss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stss_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/stss_ram.sv
module stss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/stss_ctrl.sv
module stss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  stss_pkg::dp_status_t  sts,
    output stss_pkg::cmd_t        cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_APP_RD   = 5'd1;
    localparam logic [4:0] S_APP_WR   = 5'd2;
    localparam logic [4:0] S_APP_END  = 5'd3;
    localparam logic [4:0] S_FULL     = 5'd4;
    localparam logic [4:0] S_OUT      = 5'd5;
    localparam logic [4:0] S_LIN_CHK  = 5'd6;
    localparam logic [4:0] S_PLAT     = 5'd7;
    localparam logic [4:0] S_QCMP_RD  = 5'd8;
    localparam logic [4:0] S_QCMP_EV  = 5'd9;
    localparam logic [4:0] S_SRT_CHK  = 5'd10;
    localparam logic [4:0] S_SRT_ITER = 5'd11;
    localparam logic [4:0] S_SRT_RB   = 5'd12;
    localparam logic [4:0] S_SRT_LB   = 5'd13;
    localparam logic [4:0] S_RCMP_RA  = 5'd14;
    localparam logic [4:0] S_RCMP_RB  = 5'd15;
    localparam logic [4:0] S_RCMP_EV  = 5'd16;
    localparam logic [4:0] S_SWAP_B   = 5'd17;
    localparam logic [4:0] S_BIN_CHK  = 5'd18;
    localparam logic [4:0] S_BIN_PRD  = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       bin_reg;
    logic       bin_next;
    logic       take;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        cmd.op     = stss_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.op = stss_pkg::OP_TAKE;
                    if (sts.in_term)
                    begin
                        bin_next = (sts.in_mode == stss_pkg::MODE_SORTED);
                        case (sts.in_mode)
                            stss_pkg::MODE_APPEND: state_next = sts.full ? S_FULL : S_APP_RD;
                            stss_pkg::MODE_LINEAR: state_next = S_LIN_CHK;
                            stss_pkg::MODE_SORTED: state_next = S_SRT_CHK;
                            default:               state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_APP_RD:
            begin
                cmd.op     = stss_pkg::OP_APP_RD;
                state_next = S_APP_WR;
            end
            S_APP_WR:
            begin
                cmd.op     = stss_pkg::OP_APP_WR;
                state_next = (sts.q_stop || sts.k_last) ? S_APP_END : S_APP_RD;
            end
            S_APP_END:
            begin
                cmd.op     = stss_pkg::OP_APP_END;
                state_next = S_OUT;
            end
            S_FULL:
            begin
                cmd.op     = stss_pkg::OP_FULL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = stss_pkg::OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            S_LIN_CHK:
            begin
                if (sts.i_end)
                begin
                    cmd.op     = stss_pkg::OP_NFND;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = stss_pkg::OP_PERM_RD;
                    state_next = S_PLAT;
                end
            end
            S_PLAT:
            begin
                cmd.op     = stss_pkg::OP_LAT_PA;
                state_next = S_QCMP_RD;
            end
            S_QCMP_RD:
            begin
                cmd.op     = stss_pkg::OP_QCMP_RD;
                state_next = S_QCMP_EV;
            end
            S_QCMP_EV:
            begin
                if (!sts.qc_ne && (sts.qc_z || sts.k_last))
                begin
                    cmd.op     = bin_reg ? stss_pkg::OP_BIN_HIT : stss_pkg::OP_LIN_HIT;
                    state_next = S_OUT;
                end
                else if (sts.qc_ne)
                begin
                    if (bin_reg)
                    begin
                        cmd.op     = sts.qc_gt ? stss_pkg::OP_BIN_GT : stss_pkg::OP_BIN_LT;
                        state_next = S_BIN_CHK;
                    end
                    else
                    begin
                        cmd.op     = stss_pkg::OP_I_INC;
                        state_next = S_LIN_CHK;
                    end
                end
                else
                begin
                    cmd.op     = stss_pkg::OP_K_INC;
                    state_next = S_QCMP_RD;
                end
            end
            S_SRT_CHK:
            begin
                if (sts.cnt_lt2)
                begin
                    state_next = S_BIN_CHK;
                end
                else
                begin
                    cmd.op     = stss_pkg::OP_SRT_PASS;
                    state_next = S_SRT_ITER;
                end
            end
            S_SRT_ITER:
            begin
                if (sts.ip1_end)
                begin
                    if (sts.swapped)
                    begin
                        cmd.op = stss_pkg::OP_SRT_PASS;
                    end
                    else
                    begin
                        state_next = S_BIN_CHK;
                    end
                end
                else
                begin
                    cmd.op     = stss_pkg::OP_PERM_RD;
                    state_next = S_SRT_RB;
                end
            end
            S_SRT_RB:
            begin
                cmd.op     = stss_pkg::OP_SRT_RB;
                state_next = S_SRT_LB;
            end
            S_SRT_LB:
            begin
                cmd.op     = stss_pkg::OP_LAT_PB;
                state_next = S_RCMP_RA;
            end
            S_RCMP_RA:
            begin
                cmd.op     = stss_pkg::OP_RCMP_RA;
                state_next = S_RCMP_RB;
            end
            S_RCMP_RB:
            begin
                cmd.op     = stss_pkg::OP_RCMP_RB;
                state_next = S_RCMP_EV;
            end
            S_RCMP_EV:
            begin
                if (sts.rc_gt)
                begin
                    cmd.op     = stss_pkg::OP_SWAP_A;
                    state_next = S_SWAP_B;
                end
                else if (sts.rc_ne || sts.rc_z || sts.k_last)
                begin
                    cmd.op     = stss_pkg::OP_I_INC;
                    state_next = S_SRT_ITER;
                end
                else
                begin
                    cmd.op     = stss_pkg::OP_K_INC;
                    state_next = S_RCMP_RA;
                end
            end
            S_SWAP_B:
            begin
                cmd.op     = stss_pkg::OP_SWAP_B;
                state_next = S_SRT_ITER;
            end
            S_BIN_CHK:
            begin
                if (sts.bin_end)
                begin
                    cmd.op     = stss_pkg::OP_NFND;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = stss_pkg::OP_BIN_MID;
                    state_next = S_BIN_PRD;
                end
            end
            S_BIN_PRD:
            begin
                cmd.op     = stss_pkg::OP_BIN_PRD;
                state_next = S_PLAT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
        end
    end

endmodule

FILE: rtl/stss_dp.sv
module stss_dp #(
    parameter int MAX_ENTRIES = stss_pkg::MAX_ENTRIES,
    parameter int NAME_BYTES  = stss_pkg::NAME_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stss_pkg::cmd_t        cmd,
    output stss_pkg::dp_status_t  sts,
    input  stss_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output stss_pkg::out_item_t   out_data
);

    localparam int SLOT_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int BYTE_W  = $clog2(NAME_BYTES);
    localparam int NADDR_W = $clog2(MAX_ENTRIES * NAME_BYTES);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] qlen_reg, qlen_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi1_reg, hi1_next;
    logic [SLOT_W-1:0] mid_reg, mid_next;
    logic [SLOT_W-1:0] pa_reg, pa_next;
    logic [SLOT_W-1:0] pb_reg, pb_next;
    logic [7:0]        byte_a_reg, byte_a_next;
    logic              swapped_reg, swapped_next;
    logic              trunc_reg, trunc_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [6:0]        res_slot_reg, res_slot_next;
    stss_pkg::out_item_t out_data_reg, out_data_next;

    logic              name_we;
    logic [SLOT_W-1:0] name_row;
    logic [NADDR_W-1:0] name_addr;
    logic [7:0]        name_rdata;
    logic              q_we;
    logic [BYTE_W-1:0] q_addr;
    logic [7:0]        q_wdata;
    logic [7:0]        q_rdata;
    logic              perm_we;
    logic [SLOT_W-1:0] perm_addr;
    logic [SLOT_W-1:0] perm_wdata;
    logic [SLOT_W-1:0] perm_rdata;

    logic              in_term;
    logic              q_room;
    logic [CNT_W:0]    mid_sum;

    assign in_term = (in_data.char_byte == 8'd0);
    assign q_room  = (qlen_reg != BYTE_W'(NAME_BYTES - 1));
    assign mid_sum = (CNT_W + 1)'(lo_reg) + (CNT_W + 1)'(hi1_reg) - (CNT_W + 1)'(1);

    assign name_row  = (cmd.op == stss_pkg::OP_RCMP_RB) ? pb_reg : pa_reg;
    assign name_addr = NADDR_W'(name_row) * NADDR_W'(NAME_BYTES) + NADDR_W'(k_reg);
    assign name_we   = (cmd.op == stss_pkg::OP_APP_WR);

    assign q_we    = (cmd.op == stss_pkg::OP_TAKE) && (in_term || q_room);
    assign q_addr  = (cmd.op == stss_pkg::OP_TAKE) ? qlen_reg : k_reg;
    assign q_wdata = in_data.char_byte;

    always_comb
    begin
        perm_we    = 1'b0;
        perm_addr  = SLOT_W'(i_reg);
        perm_wdata = pb_reg;
        case (cmd.op)
            stss_pkg::OP_SRT_RB:  perm_addr = SLOT_W'(i_reg + CNT_W'(1));
            stss_pkg::OP_BIN_PRD: perm_addr = mid_reg;
            stss_pkg::OP_APP_END:
            begin
                perm_we    = 1'b1;
                perm_addr  = SLOT_W'(count_reg);
                perm_wdata = SLOT_W'(count_reg);
            end
            stss_pkg::OP_SWAP_A:
            begin
                perm_we    = 1'b1;
                perm_wdata = pb_reg;
            end
            stss_pkg::OP_SWAP_B:
            begin
                perm_we    = 1'b1;
                perm_addr  = SLOT_W'(i_reg + CNT_W'(1));
                perm_wdata = pa_reg;
            end
            default:
            begin
                perm_we = 1'b0;
            end
        endcase
    end

    stss_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * NAME_BYTES)) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .addr  (name_addr),
        .wdata (q_rdata),
        .rdata (name_rdata)
    );

    stss_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_query_ram (
        .clk   (clk),
        .we    (q_we),
        .addr  (q_addr),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    stss_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .addr  (perm_addr),
        .wdata (perm_wdata),
        .rdata (perm_rdata)
    );

    always_comb
    begin
        sts.in_term  = in_term;
        sts.in_mode  = in_data.mode;
        sts.full     = (count_reg == CNT_W'(MAX_ENTRIES));
        sts.cnt_lt2  = (count_reg < CNT_W'(2));
        sts.i_end    = (i_reg == count_reg);
        sts.ip1_end  = ((CNT_W + 1)'(i_reg) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(count_reg);
        sts.bin_end  = (lo_reg >= hi1_reg);
        sts.swapped  = swapped_reg;
        sts.k_last   = (k_reg == BYTE_W'(NAME_BYTES - 1));
        sts.q_stop   = (q_rdata == 8'd0);
        sts.qc_ne    = (name_rdata != q_rdata);
        sts.qc_gt    = (name_rdata > q_rdata);
        sts.qc_z     = (name_rdata == 8'd0);
        sts.rc_ne    = (byte_a_reg != name_rdata);
        sts.rc_gt    = (byte_a_reg > name_rdata);
        sts.rc_z     = (byte_a_reg == 8'd0);
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_next      = count_reg;
        qlen_next       = qlen_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        k_next          = k_reg;
        i_next          = i_reg;
        lo_next         = lo_reg;
        hi1_next        = hi1_reg;
        mid_next        = mid_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        byte_a_next     = byte_a_reg;
        swapped_next    = swapped_reg;
        trunc_next      = trunc_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_data_next   = out_data_reg;
        case (cmd.op)
            stss_pkg::OP_TAKE:
            begin
                if (in_term)
                begin
                    trunc_next = ovf_reg;
                    qlen_next  = '0;
                    ovf_next   = 1'b0;
                    k_next     = '0;
                    i_next     = '0;
                    lo_next    = '0;
                    hi1_next   = count_reg;
                    pa_next    = SLOT_W'(count_reg);
                end
                else if (q_room)
                begin
                    qlen_next = qlen_reg + BYTE_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            stss_pkg::OP_APP_WR:
            begin
                k_next = k_reg + BYTE_W'(1);
            end
            stss_pkg::OP_APP_END:
            begin
                count_next      = count_reg + CNT_W'(1);
                res_status_next = stss_pkg::ST_ADDED;
                res_slot_next   = 7'(count_reg);
            end
            stss_pkg::OP_FULL:
            begin
                res_status_next = stss_pkg::ST_FULL;
                res_slot_next   = '0;
            end
            stss_pkg::OP_OUT_LOAD:
            begin
                out_valid_next            = 1'b1;
                out_data_next.status      = res_status_reg;
                out_data_next.slot_index  = res_slot_reg;
                out_data_next.entry_total = 8'(count_reg);
                out_data_next.truncated   = trunc_reg;
            end
            stss_pkg::OP_LAT_PA:
            begin
                pa_next = perm_rdata;
                k_next  = '0;
            end
            stss_pkg::OP_K_INC:
            begin
                k_next = k_reg + BYTE_W'(1);
            end
            stss_pkg::OP_LIN_HIT:
            begin
                res_status_next = stss_pkg::ST_FOUND;
                res_slot_next   = 7'(i_reg);
            end
            stss_pkg::OP_I_INC:
            begin
                i_next = i_reg + CNT_W'(1);
            end
            stss_pkg::OP_NFND:
            begin
                res_status_next = stss_pkg::ST_NOT_FOUND;
                res_slot_next   = '0;
            end
            stss_pkg::OP_SRT_PASS:
            begin
                i_next       = '0;
                swapped_next = 1'b0;
            end
            stss_pkg::OP_SRT_RB:
            begin
                pa_next = perm_rdata;
            end
            stss_pkg::OP_LAT_PB:
            begin
                pb_next = perm_rdata;
                k_next  = '0;
            end
            stss_pkg::OP_RCMP_RB:
            begin
                byte_a_next = name_rdata;
            end
            stss_pkg::OP_SWAP_B:
            begin
                swapped_next = 1'b1;
                i_next       = i_reg + CNT_W'(1);
            end
            stss_pkg::OP_BIN_MID:
            begin
                mid_next = SLOT_W'(mid_sum >> 1);
            end
            stss_pkg::OP_BIN_HIT:
            begin
                res_status_next = stss_pkg::ST_FOUND;
                res_slot_next   = 7'(mid_reg);
            end
            stss_pkg::OP_BIN_LT:
            begin
                lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            end
            stss_pkg::OP_BIN_GT:
            begin
                hi1_next = CNT_W'(mid_reg);
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            qlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            qlen_reg      <= qlen_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        i_reg          <= i_next;
        lo_reg         <= lo_next;
        hi1_reg        <= hi1_next;
        mid_reg        <= mid_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        byte_a_reg     <= byte_a_next;
        swapped_reg    <= swapped_next;
        trunc_reg      <= trunc_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/tb.sv
module tb;

    localparam int ROWS  = stss_pkg::MAX_ENTRIES + 1;
    localparam int QROW  = stss_pkg::MAX_ENTRIES;
    localparam int LIMIT = 40000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    stss_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    stss_pkg::out_item_t out_data;

    stss_pkg::in_item_t  byte_q[$];
    stss_pkg::out_item_t answer_q[$];

    logic [7:0] names[ROWS][stss_pkg::NAME_BYTES];
    int         slot_row[stss_pkg::MAX_ENTRIES];
    int         name_cnt;
    int         qlen;
    bit         qcut;

    int  send_idle = 0;
    int  recv_stall = 0;
    bit  took = 1'b0;
    bit  hold_on = 1'b0;
    int  hold_ticks = 0;
    int  errs = 0;
    int  cycles = 0;
    logic [7:0] alph[4] = '{8'h01, 8'h41, 8'h80, 8'hff};

    string_table_sort_and_search dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #10 clk = ~clk;

    function automatic int name_order(int a, int b);
        for (int k = 0; k < stss_pkg::NAME_BYTES; k++)
        begin
            if (names[a][k] != names[b][k])
                return (names[a][k] < names[b][k]) ? -1 : 1;
            if (names[a][k] == 8'h00)
                return 0;
        end
        return 0;
    endfunction

    function automatic void sort_slots();
        int t;
        int j;
        for (int i = 1; i < name_cnt; i++)
        begin
            t = slot_row[i];
            j = i - 1;
            while (j >= 0 && name_order(slot_row[j], t) > 0)
            begin
                slot_row[j + 1] = slot_row[j];
                j--;
            end
            slot_row[j + 1] = t;
        end
    endfunction

    function automatic void lookup_name(stss_pkg::in_item_t it);
        stss_pkg::out_item_t r;
        int lo;
        int hi;
        int mid;
        int c;
        if (it.char_byte != 8'h00)
        begin
            if (qlen < stss_pkg::NAME_BYTES - 1)
            begin
                names[QROW][qlen] = it.char_byte;
                qlen++;
            end
            else
                qcut = 1'b1;
            return;
        end
        names[QROW][qlen] = 8'h00;
        r = '0;
        r.truncated = qcut;
        qlen = 0;
        qcut = 1'b0;
        if (it.mode == stss_pkg::MODE_APPEND)
        begin
            if (name_cnt >= stss_pkg::MAX_ENTRIES)
                r.status = stss_pkg::ST_FULL;
            else
            begin
                names[name_cnt] = names[QROW];
                slot_row[name_cnt] = name_cnt;
                r.slot_index = name_cnt[6:0];
                name_cnt++;
                r.status = stss_pkg::ST_ADDED;
            end
        end
        else if (it.mode == stss_pkg::MODE_LINEAR)
        begin
            r.status = stss_pkg::ST_NOT_FOUND;
            for (int i = 0; i < name_cnt; i++)
                if (name_order(slot_row[i], QROW) == 0)
                begin
                    r.status = stss_pkg::ST_FOUND;
                    r.slot_index = i[6:0];
                    break;
                end
        end
        else if (it.mode == stss_pkg::MODE_SORTED)
        begin
            sort_slots();
            r.status = stss_pkg::ST_NOT_FOUND;
            lo = 0;
            hi = name_cnt - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                c = name_order(slot_row[mid], QROW);
                if (c == 0)
                begin
                    r.status = stss_pkg::ST_FOUND;
                    r.slot_index = mid[6:0];
                    break;
                end
                else if (c > 0)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        else
            return;
        r.entry_total = name_cnt[7:0];
        answer_q.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        took <= in_valid && in_ready;
        if (in_valid && in_ready)
            lookup_name(in_data);
        if (out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                errs++;
                if (errs <= 10)
                    $display("unexpected transfer %p", out_data);
            end
            else if (answer_q[0] !== out_data)
            begin
                errs++;
                if (errs <= 10)
                    $display("mismatch: expected %p actual %p", answer_q[0], out_data);
                void'(answer_q.pop_front());
            end
            else
                void'(answer_q.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || took))
        begin
            if (byte_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                in_data <= byte_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && !hold_on && ($urandom_range(99) >= recv_stall);

    always @(negedge clk)
        if (hold_on)
            hold_ticks <= hold_ticks + 1;

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return alph[r % 4];
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic push_name(logic [1:0] m, int len);
        stss_pkg::in_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.mode = 2'($urandom_range(3));
            it.char_byte = pick_char();
            byte_q.push_back(it);
        end
        it.mode = m;
        it.char_byte = 8'h00;
        byte_q.push_back(it);
    endtask

    task automatic push_text(logic [1:0] m, logic [7:0] a, logic [7:0] b);
        stss_pkg::in_item_t it;
        it.mode = 2'($urandom_range(3));
        it.char_byte = a;
        byte_q.push_back(it);
        if (b != 8'h00)
        begin
            it.char_byte = b;
            byte_q.push_back(it);
        end
        it.mode = m;
        it.char_byte = 8'h00;
        byte_q.push_back(it);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (byte_q.size() != 0 || in_valid || answer_q.size() != 0);
    endtask

    task automatic random_names(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                push_name(stss_pkg::MODE_APPEND, $urandom_range(3));
            else if (r < 80)
                push_name(stss_pkg::MODE_LINEAR, $urandom_range(3));
            else if (r < 85)
                push_name(stss_pkg::MODE_SORTED, $urandom_range(3));
            else
                push_name(stss_pkg::MODE_DISCARD, $urandom_range(4));
        end
    endtask

    initial
    begin
        name_cnt = 0;
        qlen = 0;
        qcut = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_name(stss_pkg::MODE_LINEAR, 0);
        push_text(stss_pkg::MODE_SORTED, 8'h41, 8'h00);
        push_name(stss_pkg::MODE_APPEND, 0);
        push_text(stss_pkg::MODE_APPEND, 8'hff, 8'h00);
        push_text(stss_pkg::MODE_APPEND, 8'h41, 8'h01);
        push_text(stss_pkg::MODE_DISCARD, 8'h7e, 8'h00);
        push_text(stss_pkg::MODE_APPEND, 8'h41, 8'h00);
        push_text(stss_pkg::MODE_LINEAR, 8'h41, 8'h01);
        push_text(stss_pkg::MODE_SORTED, 8'h41, 8'h00);
        push_name(stss_pkg::MODE_SORTED, 0);
        push_text(stss_pkg::MODE_SORTED, 8'h42, 8'h00);
        push_text(stss_pkg::MODE_LINEAR, 8'hff, 8'h00);
        push_name(stss_pkg::MODE_APPEND, stss_pkg::NAME_BYTES);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 33) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 72 : 33) : 0;
            random_names(4);
            if (ph == 2)
            begin
                @(posedge clk);
                hold_on = 1'b1;
                wait (hold_ticks >= 4000);
                @(posedge clk);
                hold_on = 1'b0;
            end
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        for (int i = name_cnt; i <= stss_pkg::MAX_ENTRIES; i++)
            push_name(stss_pkg::MODE_APPEND, 0);
        push_name(stss_pkg::MODE_SORTED, 1);
        push_name(stss_pkg::MODE_LINEAR, 1);
        push_name(stss_pkg::MODE_APPEND, 2);
        push_name(stss_pkg::MODE_SORTED, 0);
        drain();
        repeat (3000) @(posedge clk);

        errs += answer_q.size();
        if (errs == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
